// ----- hdl/tcp_flow_sequence_tracker_unit_defines.svh -----
// Assertion macros shared by the flow sequence tracker RTL.
// Each macro expects i_clk and i_rst_n to be visible in the including module.
`ifndef TCP_FLOW_SEQUENCE_TRACKER_UNIT_DEFINES_SVH
`define TCP_FLOW_SEQUENCE_TRACKER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCPFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCPFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tcpft_pkg.sv -----
// Package of the flow sequence tracker: transaction types, constants, generator.
// Used by tcp_flow_sequence_tracker_unit; depends on nothing.
`default_nettype none

package tcpft_pkg;

    localparam int FLOWS_DEF     = 16;
    localparam int CHUNK_MAX_DEF = 65535;

    localparam logic [15:0] FLAGS_SENT = 16'h5018;
    localparam logic [15:0] FLAGS_RECV = 16'h5010;
    localparam logic [16:0] HDR_BYTES  = 17'd40;

    typedef struct packed {
        logic        is_sent;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [20:0] payload_length;
    } t_in;

    typedef struct packed {
        logic [31:0] out_src_addr;
        logic [31:0] out_dst_addr;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] tcp_flags;
        logic [15:0] ip_total_length;
        logic [16:0] record_length;
        logic [15:0] chunk_length;
        logic        last_packet;
        logic        table_full;
    } t_out;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tcpft_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the flow key and flow counter tables.
`default_nettype none

module tcpft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/tcp_flow_sequence_tracker_unit.sv -----
// Top level of the TCP flow sequence tracker: flow lookup, insertion and chunking.
// Depends on tcpft_pkg, tcpft_ram and tcp_flow_sequence_tracker_unit_defines.svh.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------
//  in      | input     | i_in_valid/o_in_stall   | i_in_data  (t_in)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (rng_seed)
//
// An input transaction first sweeps the flow table, one RAM read per cycle, and a miss
// with a free slot then passes through an insertion state that claims the slot. Each
// chunk is then loaded into the output register whenever it is empty or not stalled.
// Reset clears the valid bits and loads the generator with 1; there is no sweep.
// Output stalls hold the chunk sequencer; input is stalled while a transaction is busy.
`default_nettype none

`include "tcp_flow_sequence_tracker_unit_defines.svh"

module tcp_flow_sequence_tracker_unit #(
    parameter int FLOWS     = tcpft_pkg::FLOWS_DEF,
    parameter int CHUNK_MAX = tcpft_pkg::CHUNK_MAX_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire tcpft_pkg::t_in   i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output tcpft_pkg::t_out       o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [31:0]      i_cfg_data
);

    localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int KW = 96;
    localparam int CW = 64;
    localparam logic [IW-1:0] LAST_IDX = IW'(FLOWS - 1);
    localparam logic [20:0] CHUNK_LIM = 21'(CHUNK_MAX);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_INSERT = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    tcpft_pkg::t_in    r_in, n_in;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_issued_all, n_issued_all;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_free_found, n_free_found;
    logic [IW-1:0]     r_free, n_free;
    logic [IW-1:0]     r_slot, n_slot;
    logic              r_full, n_full;
    logic [31:0]       r_seq, n_seq;
    logic [31:0]       r_ack, n_ack;
    logic [20:0]       r_remain, n_remain;
    logic [FLOWS-1:0]  r_valid, n_valid;
    logic [31:0]       r_rng, n_rng;
    logic              r_out_valid, n_out_valid;
    tcpft_pkg::t_out   r_out, n_out;

    logic              w_key_we, w_cnt_we;
    logic [IW-1:0]     w_cnt_waddr;
    logic [KW-1:0]     w_key_wdata, w_key_rdata, w_fwd_key, w_rev_key;
    logic [CW-1:0]     w_cnt_wdata, w_cnt_rdata;
    logic              w_hit, w_load, w_last;
    logic [15:0]       w_chunk;
    logic [16:0]       w_len40;
    logic [31:0]       w_draw1, w_draw2, w_seq_upd, w_ack_upd;

    tcpft_ram #(.WIDTH(KW), .DEPTH(FLOWS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_free),
        .i_wdata (w_key_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_key_rdata)
    );

    tcpft_ram #(.WIDTH(CW), .DEPTH(FLOWS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_cnt_rdata)
    );

    assign w_fwd_key = {r_in.source_ip, r_in.dest_ip, r_in.source_port, r_in.dest_port};
    assign w_rev_key = {r_in.dest_ip, r_in.source_ip, r_in.dest_port, r_in.source_port};
    assign w_hit = r_cmp_vld && r_valid[r_cmp_idx]
                   && ((w_key_rdata == w_fwd_key) || (w_key_rdata == w_rev_key));

    assign w_draw1 = tcpft_pkg::xorshift32(r_rng);
    assign w_draw2 = tcpft_pkg::xorshift32(w_draw1);

    assign w_last  = (r_remain <= CHUNK_LIM);
    assign w_chunk = w_last ? r_remain[15:0] : 16'(CHUNK_MAX);
    assign w_len40 = {1'b0, w_chunk} + tcpft_pkg::HDR_BYTES;
    assign w_load  = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    assign w_seq_upd = r_in.is_sent ? (r_seq + {16'd0, w_chunk}) : r_seq;
    assign w_ack_upd = r_in.is_sent ? r_ack : (r_ack + {16'd0, w_chunk});

    assign w_key_we    = (r_state == S_INSERT);
    assign w_key_wdata = w_fwd_key;
    assign w_cnt_we    = (r_state == S_INSERT) || (w_load && w_last && !r_full);
    assign w_cnt_waddr = (r_state == S_INSERT) ? r_free : r_slot;
    assign w_cnt_wdata = (r_state == S_INSERT) ? {w_draw2, w_draw1} : {w_seq_upd, w_ack_upd};

    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_rd_idx     = r_rd_idx;
        n_issued_all = r_issued_all;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_slot       = r_slot;
        n_full       = r_full;
        n_seq        = r_seq;
        n_ack        = r_ack;
        n_remain     = r_remain;
        n_valid      = r_valid;
        n_rng        = r_rng;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in         = i_in_data;
                    n_remain     = i_in_data.payload_length;
                    n_rd_idx     = '0;
                    n_issued_all = 1'b0;
                    n_free_found = 1'b0;
                    n_full       = 1'b0;
                    n_state      = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (!r_issued_all) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx;
                    if (r_rd_idx == LAST_IDX) begin
                        n_issued_all = 1'b1;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free       = r_cmp_idx;
                end
                if (w_hit) begin
                    n_slot    = r_cmp_idx;
                    n_seq     = w_cnt_rdata[63:32];
                    n_ack     = w_cnt_rdata[31:0];
                    n_cmp_vld = 1'b0;
                    n_state   = (r_remain == '0) ? S_IDLE : S_EMIT;
                end else if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    if (r_free_found || !r_valid[r_cmp_idx]) begin
                        n_state = S_INSERT;
                    end else begin
                        n_full  = 1'b1;
                        n_seq   = '0;
                        n_ack   = '0;
                        n_state = (r_remain == '0) ? S_IDLE : S_EMIT;
                    end
                end
            end
            S_INSERT: begin
                n_valid[r_free] = 1'b1;
                n_slot          = r_free;
                n_ack           = w_draw1;
                n_seq           = w_draw2;
                n_rng           = w_draw2;
                n_state         = (r_remain == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid            = 1'b1;
                    n_out.out_src_addr     = r_in.is_sent ? r_in.source_ip : r_in.dest_ip;
                    n_out.out_dst_addr     = r_in.is_sent ? r_in.dest_ip : r_in.source_ip;
                    n_out.out_src_port     = r_in.is_sent ? r_in.source_port : r_in.dest_port;
                    n_out.out_dst_port     = r_in.is_sent ? r_in.dest_port : r_in.source_port;
                    n_out.seq_number       = r_in.is_sent ? r_seq : r_ack;
                    n_out.ack_number       = r_in.is_sent ? r_ack : r_seq;
                    n_out.tcp_flags        = r_in.is_sent ? tcpft_pkg::FLAGS_SENT
                                                          : tcpft_pkg::FLAGS_RECV;
                    n_out.ip_total_length  = w_len40[15:0];
                    n_out.record_length    = w_len40;
                    n_out.chunk_length     = w_chunk;
                    n_out.last_packet      = w_last;
                    n_out.table_full       = r_full;
                    n_remain               = r_remain - {5'd0, w_chunk};
                    if (!r_full) begin
                        n_seq = w_seq_upd;
                        n_ack = w_ack_upd;
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_rng = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_rng       <= 32'd1;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_rng       <= n_rng;
            r_out_valid <= n_out_valid;
            r_cmp_vld   <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_rd_idx     <= n_rd_idx;
        r_issued_all <= n_issued_all;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_slot       <= n_slot;
        r_full       <= n_full;
        r_seq        <= n_seq;
        r_ack        <= n_ack;
        r_remain     <= n_remain;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    `TCPFT_ASSERT_NOW(a_emit_slot_valid, (r_state == S_EMIT) && !r_full, r_valid[r_slot],
        "Chunk emission uses a flow slot that is not valid.")
    `TCPFT_ASSERT_NOW(a_insert_slot_free, r_state == S_INSERT, !r_valid[r_free],
        "Insertion targets a slot that already holds a flow.")
    `TCPFT_ASSERT_NOW(a_full_zero_counts, o_out_valid && o_out_data.table_full,
        (o_out_data.seq_number == 32'd0) && (o_out_data.ack_number == 32'd0),
        "A transaction without a stored flow carries nonzero counters.")
    `TCPFT_ASSERT_NOW(a_record_length, o_out_valid,
        o_out_data.record_length == ({1'b0, o_out_data.chunk_length} + 17'd40),
        "Record length does not match the chunk length plus the header.")
    `TCPFT_ASSERT_NEXT(a_last_to_idle, w_load && w_last, r_state == S_IDLE,
        "The sequencer did not return to idle after the final chunk.")

endmodule

`default_nettype wire
